/* rtl/prescaled_rollover_timer_top_macros.svh */
// ----------------------------------------------------------------------------
// Prescaled rollover timer assertion macros
// Shared concurrent assertion forms for the timer checker.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_ROLLOVER_TIMER_TOP_MACROS_SVH
`define PRESCALED_ROLLOVER_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication, disabled during reset.
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

/* rtl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// Prescaled rollover timer package
// Item types, register indexes, access modes and control bit positions.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Access modes carried in each input item
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register word indexes
  localparam logic [3:0] REG_CONTROL   = 4'd0;
  localparam logic [3:0] REG_PRESCALER = 4'd1;
  localparam logic [3:0] REG_STATUS    = 4'd2;
  localparam logic [3:0] REG_IRQ_EN    = 4'd3;
  localparam logic [3:0] REG_COUNTER   = 4'd9;

  // Control and status bit positions
  localparam int unsigned CTRL_EN  = 0;
  localparam int unsigned CTRL_SWR = 15;
  localparam int unsigned STAT_ROV = 5;

  // Control bits kept across a software reset (enable and mode bits)
  localparam logic [31:0] CTRL_KEEP_ON_SWR = 32'h0000_003F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } prt_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic [63:0] extended_ticks;
  } prt_out_t;

endpackage

/* rtl/prescaled_rollover_timer_top.sv */
// ----------------------------------------------------------------------------
// Prescaled rollover timer
// Free-running prescaled counter with rollover flag, interrupt and
// extended tick count, driven by a stream of tick/read/write items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): each item is one
//   clock tick, one register read or one register write. An item is taken
//   at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result item per input item, in order, carrying read data (zero unless
//   a read), the interrupt line and the 64-bit extended tick count, all as
//   they stand after the item's effect.
//   Each result is registered, in the output or skid register.
//   Throughput: one item per cycle while in_stall_o is low; the whole
//   register map update is one logic pass from timer state to result register.
//   Stall: a result held by out_stall_i stays stable; one further item is
//   still taken and parked in a skid register, after which in_stall_o
//   rises until the held result is taken and the parked one moves up.
//   Reset: rst_ni clears all timer registers, the counter, the prescaler
//   and both result valid flags; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module prescaled_rollover_timer_top
  import prt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned PRESCALE_WIDTH = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  prt_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output prt_out_t out_item_o
);

  logic     accept;
  logic     out_free;
  prt_out_t result;

  logic     out_vld_q;
  prt_out_t out_q;
  logic     skid_vld_q;
  prt_out_t skid_q;

  // Take an item whenever the skid slot is empty
  assign accept   = in_valid_i & ~skid_vld_q;
  // Output slot frees when empty or being taken this cycle
  assign out_free = ~out_vld_q | ~out_stall_i;

  prt_core #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .PRESCALE_WIDTH(PRESCALE_WIDTH)
  ) u_prt_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .result_o(result)
  );

  // Output register with a one-entry skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        // drain the parked result first
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      // output held: park the new result
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/prt_core.sv */
// ----------------------------------------------------------------------------
// Prescaled rollover timer core
// Register map, prescaler, main counter and rollover bookkeeping.
// ----------------------------------------------------------------------------
module prt_core
  import prt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned PRESCALE_WIDTH = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  prt_in_t  item_i,
  output prt_out_t result_o
);

  logic [31:0]               ctrl_q, ctrl_d;
  logic [PRESCALE_WIDTH-1:0] presc_set_q, presc_set_d;
  logic [PRESCALE_WIDTH-1:0] presc_cnt_q, presc_cnt_d;
  logic                      flag_q, flag_d;
  logic                      irq_en_q, irq_en_d;
  logic [COUNT_WIDTH-1:0]    main_q, main_d;
  logic [31:0]               roll_q, roll_d;
  logic [31:0]               rd_data;

  always_comb begin
    ctrl_d      = ctrl_q;
    presc_set_d = presc_set_q;
    presc_cnt_d = presc_cnt_q;
    flag_d      = flag_q;
    irq_en_d    = irq_en_q;
    main_d      = main_q;
    roll_d      = roll_q;
    rd_data     = '0;

    case (item_i.mode)
      MODE_TICK: begin
        if (ctrl_q[CTRL_EN]) begin
          // count on the tick that finds the prescaler at or past its setting
          if (presc_cnt_q >= presc_set_q) begin
            presc_cnt_d = '0;
            main_d      = main_q + 1'b1;
            if (&main_q) begin
              flag_d = 1'b1;
              roll_d = roll_q + 32'd1;
            end
          end else begin
            presc_cnt_d = presc_cnt_q + 1'b1;
          end
        end
      end
      MODE_READ: begin
        case (item_i.reg_index)
          REG_CONTROL:   rd_data = ctrl_q;
          REG_PRESCALER: rd_data = 32'(presc_set_q);
          REG_STATUS:    rd_data = 32'(flag_q) << STAT_ROV;
          REG_IRQ_EN:    rd_data = 32'(irq_en_q) << STAT_ROV;
          REG_COUNTER:   rd_data = 32'(main_q);
          default:       rd_data = '0;
        endcase
      end
      MODE_WRITE: begin
        case (item_i.reg_index)
          REG_CONTROL: begin
            if (item_i.write_data[CTRL_SWR]) begin
              // software reset: keep enable and mode bits, clear the rest
              ctrl_d      = item_i.write_data & CTRL_KEEP_ON_SWR;
              presc_set_d = '0;
              presc_cnt_d = '0;
              flag_d      = 1'b0;
              irq_en_d    = 1'b0;
              main_d      = '0;
              roll_d      = '0;
            end else begin
              ctrl_d = item_i.write_data;
            end
          end
          REG_PRESCALER: presc_set_d = item_i.write_data[PRESCALE_WIDTH-1:0];
          REG_STATUS: begin
            if (item_i.write_data[STAT_ROV]) begin
              flag_d = 1'b0;
            end
          end
          REG_IRQ_EN: irq_en_d = item_i.write_data[STAT_ROV];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      presc_set_q <= '0;
      presc_cnt_q <= '0;
      flag_q      <= 1'b0;
      irq_en_q    <= 1'b0;
      main_q      <= '0;
      roll_q      <= '0;
    end else if (accept_i) begin
      ctrl_q      <= ctrl_d;
      presc_set_q <= presc_set_d;
      presc_cnt_q <= presc_cnt_d;
      flag_q      <= flag_d;
      irq_en_q    <= irq_en_d;
      main_q      <= main_d;
      roll_q      <= roll_d;
    end
  end

  assign result_o.read_data      = rd_data;
  assign result_o.irq_line       = flag_d & irq_en_d;
  assign result_o.extended_ticks = 64'({roll_d, main_d});

endmodule

/* rtl/prt_checker.sv */
// ----------------------------------------------------------------------------
// Prescaled rollover timer checker
// Port-level assertions on the timer's two channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "prescaled_rollover_timer_top_macros.svh"

module prt_checker
  import prt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input prt_out_t out_item_o
);

  // Held result keeps valid and payload
  `PRT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // Input side only backs up after a stalled result
  `PRT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

  // Item taken with a free output shows its result next cycle
  `PRT_ASSERT_NXT(a_result_next, clk_i, rst_ni, in_valid_i && !in_stall_o && (!out_valid_o || !out_stall_i), out_valid_o)

  // Input stall implies a result is waiting
  `PRT_ASSERT_IMP(a_stall_has_out, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind prescaled_rollover_timer_top prt_checker u_prt_checker (.*);
